>>> src/int_to_radix_digit_string_assert.svh
// assertion macros used by the checker file
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef INT_TO_RADIX_DIGIT_STRING_ASSERT_SVH
`define INT_TO_RADIX_DIGIT_STRING_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ITRDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ITRDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/itrds_pkg.sv
// types, codes and constants for the radix digit string block
// no dependencies; used by the interfaces, the bench and every converter module
`timescale 1ns / 1ps
`default_nettype none

package itrds_pkg;

  localparam int ValueW    = 64;
  localparam int CharW     = 7;
  localparam int MinWidthW = 7;
  localparam int OpW       = 2;
  localparam int ShiftW    = 6;
  localparam int FifoDepth = 2;

  // operation codes; every other code selects hexadecimal
  localparam logic [OpW-1:0] OP_BIN = 2'd0;
  localparam logic [OpW-1:0] OP_OCT = 2'd1;

  localparam logic [CharW-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CharW-1:0] ASCII_ALPHA = 7'd55;  // 'A' - 10
  localparam logic [3:0]       MAX_DECIMAL = 4'd9;

  localparam logic [4:0] HEX_MIN_CLAMP = 5'd16;
  localparam logic [4:0] HEX_W_SMALL   = 5'd4;
  localparam logic [4:0] HEX_W_MID     = 5'd8;
  localparam logic [4:0] HEX_W_FULL    = 5'd16;

  localparam logic [6:0] BIN_MIN_CLAMP = 7'd64;
  localparam logic [6:0] BIN_W_SMALL   = 7'd16;
  localparam logic [6:0] BIN_W_MID     = 7'd32;
  localparam logic [6:0] BIN_W_FULL    = 7'd64;

  // floor(x / 3) for x up to 66 as (x * 171) >> 9
  localparam logic [15:0] OCT_RECIP_MUL   = 16'd171;
  localparam int          OctRecipShift   = 9;

  typedef enum logic [1:0] {
    RADIX_BIN,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

  // one conversion handed from the front to the back
  typedef struct packed {
    radix_t              radix;
    logic [ValueW-1:0]   value;
    logic [ShiftW-1:0]   top_shift;   // bit offset of the most significant digit
    logic [6:0]          total_bits;  // bits covered by the whole string
  } job_t;

  function automatic logic [2:0] radix_bits(radix_t r);
    logic [2:0] b;
    case (r)
      RADIX_BIN: b = 3'd1;
      RADIX_OCT: b = 3'd3;
      RADIX_HEX: b = 3'd4;
      default:   b = 3'd4;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> src/itrds_stream_if.sv
// valid/ready channel interfaces for the request and the digit streams
// depends on itrds_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface itrds_in_if;
  logic                              valid;
  logic                              ready;
  logic [itrds_pkg::OpW-1:0]         operation;
  logic signed [itrds_pkg::ValueW-1:0] value;
  logic [itrds_pkg::MinWidthW-1:0]   min_negative_width;

  modport source(output valid, operation, value, min_negative_width, input ready);
  modport sink(input valid, operation, value, min_negative_width, output ready);
endinterface

interface itrds_out_if;
  logic                          valid;
  logic                          ready;
  logic [itrds_pkg::CharW-1:0]   digit_char;
  logic                          last;

  modport source(output valid, digit_char, last, input ready);
  modport sink(input valid, digit_char, last, output ready);
endinterface

`default_nettype wire

>>> src/itrds_fifo.sv
// two-entry job queue between the classifier and the digit emitter
// depends on itrds_pkg for the job type
`timescale 1ns / 1ps
`default_nettype none

module itrds_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire itrds_pkg::job_t push_job,
  output logic                 full,
  input  wire logic            pop,
  output itrds_pkg::job_t      pop_job,
  output logic                 empty
);

  itrds_pkg::job_t entry_r [itrds_pkg::FifoDepth];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == 2'(itrds_pkg::FifoDepth));
  assign empty   = (count_r == 2'd0);
  assign pop_job = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> src/itrds_front.sv
// request holding register and classifier: picks radix, digit count and start offset
// depends on itrds_pkg and itrds_in_if
`timescale 1ns / 1ps
`default_nettype none

module itrds_front (
  input  wire logic       clk,
  input  wire logic       rst_n,
  itrds_in_if.sink        in_chan,
  output logic            push,
  output itrds_pkg::job_t push_job,
  input  wire logic       fifo_full
);

  logic                               hold_valid_r, hold_valid_nxt;
  logic [itrds_pkg::OpW-1:0]          op_r;
  logic [itrds_pkg::ValueW-1:0]       val_r;
  logic [itrds_pkg::MinWidthW-1:0]    minw_r;

  logic       neg, is_zero, take, no_digits;
  logic [4:0] minw_hex, nz, nf, hex_n;
  logic [6:0] minw_bin, bw, bin_w;
  logic [3:0] nib;
  logic [15:0] oct_prod;
  logic [4:0]  oct_nd;
  logic [6:0]  oct_top;
  logic [4:0]  hex_top;

  assign neg     = val_r[itrds_pkg::ValueW-1];
  assign is_zero = (val_r == '0);

  always_comb begin
    minw_hex = (minw_r > 7'(itrds_pkg::HEX_MIN_CLAMP)) ? itrds_pkg::HEX_MIN_CLAMP : minw_r[4:0];
    minw_bin = (minw_r > itrds_pkg::BIN_MIN_CLAMP) ? itrds_pkg::BIN_MIN_CLAMP : minw_r;

    // highest nonzero nibble and highest non-F nibble (plus sign room)
    nz  = 5'd0;
    nf  = 5'd0;
    nib = 4'd0;
    for (int i = 0; i < 16; i++) begin
      nib = val_r[4*i +: 4];
      if (nib != 4'h0) begin
        nz = 5'(i + 1);
      end
      if (nib != 4'hF) begin
        nf = 5'(i + 1);
        if (!nib[3] && i != 15) begin
          nf = 5'(i + 2);
        end
      end
    end
    if (!neg) begin
      hex_n = nz;
    end else if (nf <= minw_hex) begin
      hex_n = minw_hex;
    end else if (nf <= itrds_pkg::HEX_W_SMALL) begin
      hex_n = itrds_pkg::HEX_W_SMALL;
    end else if (nf <= itrds_pkg::HEX_W_MID) begin
      hex_n = itrds_pkg::HEX_W_MID;
    end else begin
      hex_n = itrds_pkg::HEX_W_FULL;
    end
    hex_top = hex_n - 5'd1;

    // highest significant bit: a one for positives, a zero for negatives
    bw = 7'd0;
    for (int i = 0; i < itrds_pkg::ValueW; i++) begin
      if (neg ? !val_r[i] : val_r[i]) begin
        bw = 7'(i + 1);
      end
    end
    bin_w = bw;
    if (neg) begin
      if (bw >= minw_bin) begin
        bin_w = (bw < itrds_pkg::BIN_W_SMALL) ? itrds_pkg::BIN_W_SMALL :
                (bw < itrds_pkg::BIN_W_MID)   ? itrds_pkg::BIN_W_MID   :
                                                itrds_pkg::BIN_W_FULL;
      end else begin
        bin_w = minw_bin;
      end
    end

    // octal digit count is ceil(width / 3)
    oct_prod = ({9'd0, bin_w} + 16'd2) * itrds_pkg::OCT_RECIP_MUL;
    oct_nd   = oct_prod[itrds_pkg::OctRecipShift +: 5];
    oct_top  = {1'b0, oct_nd, 1'b0} + {2'b00, oct_nd} - 7'd3;

    push_job.value = val_r;
    no_digits      = 1'b0;
    if (is_zero) begin
      push_job.radix      = itrds_pkg::RADIX_BIN;
      push_job.top_shift  = '0;
      push_job.total_bits = 7'd1;
    end else if (op_r == itrds_pkg::OP_BIN) begin
      push_job.radix      = itrds_pkg::RADIX_BIN;
      push_job.top_shift  = 6'(bin_w - 7'd1);
      push_job.total_bits = bin_w;
    end else if (op_r == itrds_pkg::OP_OCT) begin
      push_job.radix      = itrds_pkg::RADIX_OCT;
      push_job.top_shift  = oct_top[5:0];
      push_job.total_bits = bin_w;
    end else begin
      push_job.radix      = itrds_pkg::RADIX_HEX;
      push_job.top_shift  = {hex_top[3:0], 2'b00};
      push_job.total_bits = {hex_n, 2'b00};
      // minus one with a zero minimum has no digits at all
      no_digits           = (hex_n == 5'd0);
    end
  end

  assign take           = hold_valid_r && (no_digits || !fifo_full);
  assign push           = hold_valid_r && !no_digits && !fifo_full;
  assign in_chan.ready  = !hold_valid_r || take;
  assign hold_valid_nxt = (in_chan.valid && in_chan.ready) ? 1'b1 :
                          (take ? 1'b0 : hold_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      op_r   <= in_chan.operation;
      val_r  <= in_chan.value;
      minw_r <= in_chan.min_negative_width;
    end
  end

endmodule

`default_nettype wire

>>> src/itrds_back.sv
// digit emitter: walks one job from its top digit down, one character per cycle
// while the receiver is ready; depends on itrds_pkg and itrds_out_if
`timescale 1ns / 1ps
`default_nettype none

module itrds_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire itrds_pkg::job_t job,
  input  wire logic            job_avail,
  output logic                 job_pop,
  itrds_out_if.source          out_chan
);

  itrds_pkg::back_state_t       state_r, state_nxt;
  itrds_pkg::radix_t            radix_r;
  logic [itrds_pkg::ValueW-1:0] val_r;
  logic [itrds_pkg::ShiftW-1:0] shift_r;
  logic [6:0]                   total_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [itrds_pkg::CharW-1:0]  char_r, char_nxt;
  logic                         last_r;

  logic                         emit, is_last;
  logic [2:0]                   bpd;
  logic [itrds_pkg::ValueW-1:0] shifted;
  logic [6:0]                   nb;
  logic [3:0]                   digit;

  assign bpd     = itrds_pkg::radix_bits(radix_r);
  assign shifted = val_r >> shift_r;
  assign nb      = total_r - {1'b0, shift_r};
  assign is_last = (shift_r == '0);

  always_comb begin
    // the top octal digit may carry fewer than three bits
    for (int j = 0; j < 4; j++) begin
      digit[j] = shifted[j] && (7'(j) < nb) && (3'(j) < bpd);
    end
    char_nxt = (digit > itrds_pkg::MAX_DECIMAL) ? ({3'b000, digit} + itrds_pkg::ASCII_ALPHA)
                                                : ({3'b000, digit} + itrds_pkg::ASCII_ZERO);
  end

  always_comb begin
    state_nxt     = state_r;
    job_pop       = 1'b0;
    emit          = 1'b0;
    out_valid_nxt = out_chan.ready ? 1'b0 : out_valid_r;
    case (state_r)
      itrds_pkg::BK_IDLE: begin
        if (job_avail) begin
          job_pop   = 1'b1;
          state_nxt = itrds_pkg::BK_EMIT;
        end
      end
      itrds_pkg::BK_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          emit          = 1'b1;
          out_valid_nxt = 1'b1;
          if (is_last) begin
            state_nxt = itrds_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = itrds_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itrds_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      radix_r <= job.radix;
      val_r   <= job.value;
      shift_r <= job.top_shift;
      total_r <= job.total_bits;
    end else if (emit) begin
      shift_r <= shift_r - {3'b000, bpd};
    end
    if (emit) begin
      char_r <= char_nxt;
      last_r <= is_last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.digit_char = char_r;
  assign out_chan.last       = last_r;

endmodule

`default_nettype wire

>>> src/int_to_radix_digit_string.sv
// Integer to binary/octal/hex ASCII digit string converter.
// Request channel in_chan: operation (0 binary, 1 octal, else hex), a 64-bit
// two's complement value and the minimum width used for negative values.
// Result channel out_chan: one ASCII digit per transfer, most significant
// first, with last set on the least significant digit. Zero gives "0"; a hex
// request for minus one with a zero minimum width gives no digits at all.
// The first digit passes the holding register, the job queue, the emitter
// load registers and the output register, in that order.
// Throughput: the emitter produces one digit per cycle while the receiver is
// ready; it loads each job in its idle state first, so one job is done before
// the next starts. The longest string has 64 binary digits. The front
// classifies the next request and a two-entry job queue holds up to two more
// meanwhile. Reset (synchronous, active low) empties the holding register,
// the queue and the output register. When the receiver holds ready low, the
// digit stays on the output and the emitter waits; requests keep being
// accepted until the queue and holding register are full.
// depends on itrds_pkg, itrds_stream_if, itrds_front, itrds_fifo, itrds_back
`timescale 1ns / 1ps
`default_nettype none

module int_to_radix_digit_string (
  input  wire logic   clk,
  input  wire logic   rst_n,
  itrds_in_if.sink    in_chan,
  itrds_out_if.source out_chan
);

  itrds_pkg::job_t push_job, pop_job;
  logic            push, fifo_full, job_pop, fifo_empty;

  itrds_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .push      (push),
    .push_job  (push_job),
    .fifo_full (fifo_full)
  );

  itrds_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (fifo_full),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .empty    (fifo_empty)
  );

  itrds_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (pop_job),
    .job_avail (!fifo_empty),
    .job_pop   (job_pop),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

>>> src/itrds_checker.sv
// port-level checker for the digit string converter, bound to the top level
// depends on int_to_radix_digit_string_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "int_to_radix_digit_string_assert.svh"

module itrds_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] out_digit_char,
  input wire logic       out_last
);

  logic       out_stalled;
  logic [7:0] out_payload;
  logic       char_legal;

  assign out_stalled = out_valid && !out_ready;
  assign out_payload = {out_digit_char, out_last};
  assign char_legal  = (out_digit_char >= 7'd48 && out_digit_char <= 7'd57) ||
                       (out_digit_char >= 7'd65 && out_digit_char <= 7'd70);

  // a stalled digit stays offered
  `ITRDS_ASSERT_NEXT(a_out_valid_held, clk, rst_n, out_stalled, out_valid)
  // a stalled digit does not change
  `ITRDS_ASSERT_NEXT(a_out_payload_held, clk, rst_n, out_stalled, $stable(out_payload))
  // only 0-9 and A-F leave the block
  `ITRDS_ASSERT_NOW(a_char_legal, clk, rst_n, out_valid, char_legal)
  // nothing is offered right after reset
  `ITRDS_ASSERT_NOW(a_idle_after_reset, clk, rst_n, !$past(rst_n), !out_valid)

endmodule

bind int_to_radix_digit_string itrds_checker u_itrds_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_digit_char (out_chan.digit_char),
  .out_last       (out_chan.last)
);

`default_nettype wire

>>> bench/int_to_radix_digit_string_tb.sv
// testbench for the radix digit string block: drives conversion requests and checks
// every ASCII digit against a predictor built into the bench
// depends on itrds_pkg, itrds_stream_if and the int_to_radix_digit_string top level
`timescale 1ns / 1ps

module int_to_radix_digit_string_tb;
  import itrds_pkg::*;

  localparam logic [OpW-1:0] OP_HEX = 2'd2;
  localparam logic [OpW-1:0] OP_SPARE = 2'd3;  // decodes as hex

  typedef struct {
    logic [OpW-1:0]       op;
    logic [ValueW-1:0]    value;
    logic [MinWidthW-1:0] min_width;
  } conv_request_t;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
  } digit_t;

  logic clk;
  logic rst_n;
  logic quiet;
  logic req_taken;
  int   errors;
  int   send_gap;
  int   recv_stall;

  conv_request_t pending_requests[$];
  digit_t        expected_digits[$];

  itrds_in_if  in_chan ();
  itrds_out_if out_chan ();

  int_to_radix_digit_string dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic flag_error(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // digits from the top, the top digit only holds the bits left over
  function automatic void queue_digits(logic [63:0] v, int ndig, int bpd, int total);
    int i;
    int k;
    int s;
    int nb;
    logic [63:0] d;
    digit_t dg;
    for (i = 0; i < ndig; i++) begin
      k = ndig - 1 - i;
      s = k * bpd;
      nb = total - s;
      if (nb > bpd) nb = bpd;
      d = (v >> s) & ((64'd1 << nb) - 64'd1);
      dg.ch = (d > 9) ? d[CharW-1:0] + ASCII_ALPHA : d[CharW-1:0] + ASCII_ZERO;
      dg.last = (k == 0);
      expected_digits.push_back(dg);
    end
  endfunction

  function automatic void predict_digits(logic [OpW-1:0] op, logic [63:0] v,
                                         logic [MinWidthW-1:0] min_raw);
    int minw;
    int nz;
    int nf;
    int n;
    int w;
    int i;
    logic [3:0] nib;
    logic neg;
    digit_t dg;
    neg = v[63];
    minw = min_raw;
    nz = 0;
    nf = 0;
    w = 0;
    if (v == 64'd0) begin
      dg.ch = ASCII_ZERO;
      dg.last = 1'b1;
      expected_digits.push_back(dg);
    end else if (op != OP_BIN && op != OP_OCT) begin
      if (minw > 16) minw = 16;
      for (i = 1; i <= 16; i++) begin
        nib = v[(i-1)*4 +: 4];
        if (nib != 4'h0) nz = i;
        if (nib != 4'hF) begin
          nf = i;
          // a clear top bit needs one more nibble to keep the sign
          if (!nib[3] && i != 16) nf++;
        end
      end
      n = nz;
      if (neg) begin
        if (nf <= minw) n = minw;
        else if (nf <= 4) n = 4;
        else if (nf <= 8) n = 8;
        else n = 16;
      end
      queue_digits(v, n, 4, n * 4);
    end else begin
      if (minw > 64) minw = 64;
      for (i = 1; i <= 64; i++) begin
        if (neg ? !v[i-1] : v[i-1]) w = i;
      end
      if (neg) begin
        if (w >= minw) w = (w < 16) ? 16 : (w < 32) ? 32 : 64;
        else w = minw;
      end
      if (op == OP_BIN) queue_digits(v, w, 1, w);
      else queue_digits(v, (w + 2) / 3, 3, w);
    end
  endfunction

  task automatic add_request(logic [OpW-1:0] op, logic [63:0] v, logic [MinWidthW-1:0] mw);
    conv_request_t r;
    r.op = op;
    r.value = v;
    r.min_width = mw;
    pending_requests.push_back(r);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: v = 64'($urandom_range(1, 255));
      2: v = 64'd0 - 64'($urandom_range(1, 300));
      3: v = v | (~64'd0 << $urandom_range(1, 63));
      4: v = v >> $urandom_range(1, 63);
      default: begin
        case ($urandom_range(0, 2))
          0: v = 64'd0;
          1: v = ~64'd0;
          default: v = 64'h8000_0000_0000_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  // request side: a new request only once the current one is taken
  always @(negedge clk) begin
    conv_request_t r;
    logic send;
    send = 1'b0;
    if (rst_n && (!in_chan.valid || req_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(1, 3) - 1;
      end else if (pending_requests.size() > 0) begin
        r = pending_requests.pop_front();
        send = 1'b1;
      end
      in_chan.valid <= send;
      if (send) begin
        in_chan.operation <= r.op;
        in_chan.value <= r.value;
        in_chan.min_negative_width <= r.min_width;
      end
    end
  end

  // digit side: random stall bursts
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (recv_stall > 0) begin
        recv_stall--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        recv_stall = $urandom_range(1, 3) - 1;
      end else begin
        rdy = 1'b1;
      end
    end
    out_chan.ready <= rdy;
  end

  always @(posedge clk) begin
    digit_t want;
    req_taken <= in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready)
      predict_digits(in_chan.operation, in_chan.value, in_chan.min_negative_width);
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_digits.size() == 0) begin
        flag_error("digit with none expected", out_chan.digit_char, 0);
      end else begin
        want = expected_digits.pop_front();
        if (out_chan.digit_char !== want.ch)
          flag_error("digit_char", out_chan.digit_char, want.ch);
        if (out_chan.last !== want.last)
          flag_error("last", out_chan.last, want.last);
      end
    end
  end

  initial begin
    int i;
    logic [OpW-1:0] op;
    logic [MinWidthW-1:0] mw;
    errors = 0;
    quiet = 1'b0;
    send_gap = 0;
    recv_stall = 0;
    req_taken = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.operation = '0;
    in_chan.value = '0;
    in_chan.min_negative_width = '0;
    out_chan.ready = 1'b0;

    // zero, small positives and the positive extreme per radix
    add_request(OP_BIN, 64'd0, 7'd1);
    add_request(OP_HEX, 64'd0, 7'd0);
    add_request(OP_BIN, 64'd1, 7'd1);
    add_request(OP_OCT, 64'd7, 7'd1);
    add_request(OP_HEX, 64'hF, 7'd1);
    add_request(OP_BIN, 64'h7FFF_FFFF_FFFF_FFFF, 7'd64);
    add_request(OP_OCT, 64'h7FFF_FFFF_FFFF_FFFF, 7'd1);
    add_request(OP_HEX, 64'h7FFF_FFFF_FFFF_FFFF, 7'd16);
    add_request(OP_SPARE, 64'h1234_5678_9ABC_DEF0, 7'd3);
    // negative extreme and minus one
    add_request(OP_BIN, 64'h8000_0000_0000_0000, 7'd1);
    add_request(OP_OCT, 64'h8000_0000_0000_0000, 7'd1);
    add_request(OP_HEX, 64'h8000_0000_0000_0000, 7'd1);
    add_request(OP_BIN, ~64'd0, 7'd0);
    add_request(OP_OCT, ~64'd0, 7'd64);
    add_request(OP_HEX, ~64'd0, 7'd0);  // no digits at all
    add_request(OP_HEX, ~64'd0, 7'd16);
    add_request(OP_SPARE, ~64'd0, 7'd127);
    // clamped minimum widths
    add_request(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFE, 7'd127);
    add_request(OP_BIN, 64'hFFFF_FFFF_FFFF_FFFB, 7'd127);
    // highest zero bit around the 16 and 32 bit boundaries
    add_request(OP_BIN, ~(64'd1 << 14), 7'd1);
    add_request(OP_BIN, ~(64'd1 << 15), 7'd1);
    add_request(OP_OCT, ~(64'd1 << 31), 7'd0);
    // hex sign nibble rule, then an octal top digit of one bit
    add_request(OP_HEX, 64'hFFFF_FFFF_FFFF_FF7F, 7'd1);
    add_request(OP_HEX, 64'hFFFF_FFFF_FFFF_F8FF, 7'd1);
    add_request(OP_OCT, 64'hFFFF_FFFF_FFFF_FFFC, 7'd10);

    for (i = 0; i < 75; i++) begin
      op = ($urandom_range(0, 9) == 0) ? OP_SPARE : OpW'($urandom_range(0, 2));
      if ($urandom_range(0, 9) == 0) mw = MinWidthW'($urandom_range(0, 127));
      else if (op >= OP_HEX && $urandom_range(0, 1) == 0) mw = MinWidthW'($urandom_range(1, 16));
      else mw = MinWidthW'($urandom_range(1, 64));
      add_request(op, random_value(), mw);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() > 15) @(posedge clk);
    quiet = 1'b1;
    while (pending_requests.size() > 0 || in_chan.valid) @(posedge clk);
    while (expected_digits.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
